// ===== rtl/span_depth_test_line_buffer_core_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the span depth-test line buffer
// Shared property wrappers; clock is clk, reset is rst_n (active low).
// ----------------------------------------------------------------------------
`ifndef SPAN_DEPTH_TEST_LINE_BUFFER_CORE_DEFINES_SVH
`define SPAN_DEPTH_TEST_LINE_BUFFER_CORE_DEFINES_SVH

// same-cycle implication
`define SDTLB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SDTLB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/sdtlb_pkg.sv =====
// ----------------------------------------------------------------------------
// sdtlb_pkg
// Types and constants shared by the span depth-test line buffer.
// ----------------------------------------------------------------------------
package sdtlb_pkg;

  localparam int X_W     = 11;
  localparam int Z_W     = 32;
  localparam int COLOR_W = 24;
  localparam int CFG_W   = 32;

  // far depth after reset: -100000.0 in Q20.12
  localparam logic signed [Z_W-1:0] FAR_DEPTH_RESET = -32'sd409600000;
  localparam logic [X_W-1:0]        LINE_WIDTH_RESET = 11'd1024;

  localparam logic signed [Z_W-1:0] Z_MAX = 32'sh7fffffff;
  localparam logic signed [Z_W-1:0] Z_MIN = 32'sh80000000;

  typedef enum logic [1:0] {
    KIND_CLEAR = 2'd0,
    KIND_SPAN  = 2'd1,
    KIND_READ  = 2'd2
  } kind_t;

  typedef enum logic {
    CFG_LINE_WIDTH = 1'b0,
    CFG_FAR_DEPTH  = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic [1:0]            kind;
    logic [X_W-1:0]        x_start;
    logic [X_W-1:0]        x_end;
    logic signed [Z_W-1:0] z_start;
    logic signed [Z_W-1:0] z_step;
    logic [7:0]            color_red;
    logic [7:0]            color_green;
    logic [7:0]            color_blue;
  } in_item_t;

  typedef struct packed {
    logic [7:0] pixel_red;
    logic [7:0] pixel_green;
    logic [7:0] pixel_blue;
    logic       line_drawn;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic clear_start;  // clear item accepted
    logic span_start;   // span item accepted
    logic rd_issue;     // read item accepted, read color line
    logic sweep;        // clearing pass active
    logic sweep_cfg;    // sweep loads far_depth register, else reset value
    logic span_run;     // span walk active
    logic out_load;     // load result register
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic span_done;
    logic sweep_last;
    logic drawn;
  } dp_sts_t;

endpackage

// ===== rtl/sdtlb_ifs.sv =====
// ----------------------------------------------------------------------------
// sdtlb channel interfaces
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface sdtlb_in_if;
  import sdtlb_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface sdtlb_out_if;
  import sdtlb_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/sdtlb_ram.sv =====
// ----------------------------------------------------------------------------
// sdtlb_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module sdtlb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/sdtlb_ctrl.sv =====
// ----------------------------------------------------------------------------
// sdtlb_ctrl
// Sequencer: item dispatch, clearing pass, span walk, result handoff.
// ----------------------------------------------------------------------------
module sdtlb_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic [1:0]         in_kind,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output sdtlb_pkg::dp_cmd_t cmd,
  input  sdtlb_pkg::dp_sts_t sts
);

  import sdtlb_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_SPAN,
    ST_RDOUT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   sweep_cfg_r, sweep_cfg_nxt;
  logic   accept;

  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    sweep_cfg_nxt = sweep_cfg_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    cmd.sweep_cfg = sweep_cfg_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_kind)
            KIND_CLEAR: begin
              cmd.clear_start = 1'b1;
              sweep_cfg_nxt   = 1'b1;
              state_nxt       = ST_CLEAR;
            end
            KIND_SPAN: begin
              cmd.span_start = 1'b1;
              state_nxt      = ST_SPAN;
            end
            KIND_READ: begin
              cmd.rd_issue = 1'b1;
              state_nxt    = ST_RDOUT;
            end
            default: ;  // unused kind: dropped
          endcase
        end
      end
      ST_CLEAR: begin
        cmd.sweep = 1'b1;
        if (sts.sweep_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SPAN: begin
        cmd.span_run = 1'b1;
        if (sts.span_done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_RDOUT: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;  // reset runs a clearing pass
      out_valid_r <= 1'b0;
      sweep_cfg_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      sweep_cfg_r <= sweep_cfg_nxt;
    end
  end

endmodule

// ===== rtl/sdtlb_dp.sv =====
// ----------------------------------------------------------------------------
// sdtlb_dp
// Datapath: config registers, depth and color lines, span z walk, result.
// ----------------------------------------------------------------------------
module sdtlb_dp #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [sdtlb_pkg::CFG_W-1:0]   cfg_wdata,
  input  sdtlb_pkg::in_item_t           in_item,
  input  sdtlb_pkg::dp_cmd_t            cmd,
  output sdtlb_pkg::dp_sts_t            sts,
  output sdtlb_pkg::out_item_t          out_item
);

  import sdtlb_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);

  // config
  logic [X_W-1:0]        line_width_r;
  logic signed [Z_W-1:0] far_depth_r;
  logic [X_W-1:0]        width_use;

  // span walk
  logic [X_W-1:0]        x_r, x_end_r;
  logic signed [Z_W-1:0] z_r, z_step_r, z_d_r;
  logic [COLOR_W-1:0]    color_r;
  logic [AW-1:0]         addr_d_r;
  logic                  pend_r;
  logic                  issue;
  logic [Z_W:0]          z_sum;
  logic signed [Z_W-1:0] z_nxt;

  // misc
  logic [AW-1:0]         cnt_r;
  logic                  drawn_r;
  logic                  rd_ok_r;
  out_item_t             out_item_r;

  // RAM ports
  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [Z_W-1:0]        depth_wdata;
  logic [COLOR_W-1:0]    color_wdata;
  logic [Z_W-1:0]        depth_rdata;
  logic [COLOR_W-1:0]    color_rdata;
  logic                  hit;

  assign width_use = (32'(line_width_r) > MAX_WIDTH) ? X_W'(MAX_WIDTH) : line_width_r;

  assign issue = cmd.span_run && (x_r < x_end_r) && (x_r < width_use);

  // saturating z advance
  assign z_sum = {z_r[Z_W-1], z_r} + {z_step_r[Z_W-1], z_step_r};
  always_comb begin
    if (z_sum[Z_W] != z_sum[Z_W-1]) begin
      z_nxt = z_sum[Z_W] ? Z_MIN : Z_MAX;
    end else begin
      z_nxt = z_sum[Z_W-1:0];
    end
  end

  assign hit = pend_r && (z_d_r >= $signed(depth_rdata));

  always_comb begin
    if (cmd.sweep) begin
      ram_we      = 1'b1;
      ram_waddr   = cnt_r;
      depth_wdata = cmd.sweep_cfg ? far_depth_r : FAR_DEPTH_RESET;
      color_wdata = '0;
    end else begin
      ram_we      = hit;
      ram_waddr   = addr_d_r;
      depth_wdata = z_d_r;
      color_wdata = color_r;
    end
  end

  sdtlb_ram #(.WIDTH(Z_W), .DEPTH(MAX_WIDTH)) u_depth_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (depth_wdata),
    .re    (issue),
    .raddr (AW'(x_r)),
    .rdata (depth_rdata)
  );

  sdtlb_ram #(.WIDTH(COLOR_W), .DEPTH(MAX_WIDTH)) u_color_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (color_wdata),
    .re    (cmd.rd_issue),
    .raddr (AW'(in_item.x_start)),
    .rdata (color_rdata)
  );

  // control-side registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_width_r <= LINE_WIDTH_RESET;
      far_depth_r  <= FAR_DEPTH_RESET;
      cnt_r        <= '0;
      pend_r       <= 1'b0;
      drawn_r      <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_LINE_WIDTH: line_width_r <= cfg_wdata[X_W-1:0];
          CFG_FAR_DEPTH:  far_depth_r  <= cfg_wdata;
          default: ;
        endcase
      end
      if (cmd.clear_start) begin
        cnt_r <= '0;
      end else if (cmd.sweep) begin
        cnt_r <= cnt_r + 1'b1;
      end
      pend_r <= issue;
      if (cmd.clear_start) begin
        drawn_r <= 1'b0;
      end else if (cmd.span_start) begin
        drawn_r <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.span_start) begin
      x_r      <= in_item.x_start;
      x_end_r  <= in_item.x_end;
      z_r      <= in_item.z_start;
      z_step_r <= in_item.z_step;
      color_r  <= {in_item.color_red, in_item.color_green, in_item.color_blue};
    end else if (issue) begin
      x_r <= x_r + 1'b1;
      z_r <= z_nxt;
    end
    if (issue) begin
      addr_d_r <= AW'(x_r);
      z_d_r    <= z_r;
    end
    if (cmd.rd_issue) begin
      rd_ok_r <= (in_item.x_start < width_use);
    end
    if (cmd.out_load) begin
      out_item_r.pixel_red   <= rd_ok_r ? color_rdata[23:16] : 8'd0;
      out_item_r.pixel_green <= rd_ok_r ? color_rdata[15:8]  : 8'd0;
      out_item_r.pixel_blue  <= rd_ok_r ? color_rdata[7:0]   : 8'd0;
      out_item_r.line_drawn  <= drawn_r;
    end
  end

  assign out_item = out_item_r;

  assign sts.span_done  = !((x_r < x_end_r) && (x_r < width_use));
  assign sts.sweep_last = (cnt_r == AW'(MAX_WIDTH - 1));
  assign sts.drawn      = drawn_r;

endmodule

// ===== rtl/span_depth_test_line_buffer_core.sv =====
// ----------------------------------------------------------------------------
// span_depth_test_line_buffer_core
// Scan-line depth test: depth and color line per pixel, span draw, pixel read.
// ----------------------------------------------------------------------------
//
//  channel | dir | beat payload                                  | handshake
//  --------+-----+-----------------------------------------------+-----------
//  in_ch   | in  | kind, x_start, x_end, z_start, z_step, color  | valid/ready
//  out_ch  | out | pixel_red/green/blue, line_drawn (reads only)  | valid/ready
//  cfg_*   | in  | cfg_index (0 line_width, 1 far_depth), wdata  | cfg_we
//
//  Span beat: the depth RAM read/compare/write loop visits one pixel per
//    cycle (read issue, then write next cycle).
//  Clear beat: every entry of both lines is written, one entry per cycle.
//  Read beat: passes through the registered color RAM read into the result
//    register, held back while that register is still held by a stalled out_ch.
//  Reset: synchronous; a clearing pass follows, in_ch
//    not ready during it, config writes taken.
//  out_ch stall does not block in_ch until a second read needs the register.
//
module span_depth_test_line_buffer_core #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                        clk,
  input  logic                        rst_n,
  sdtlb_in_if.sink                    in_ch,
  sdtlb_out_if.source                 out_ch,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [sdtlb_pkg::CFG_W-1:0] cfg_wdata
);

  import sdtlb_pkg::*;

  `include "span_depth_test_line_buffer_core_defines.svh"

  dp_cmd_t cmd;
  dp_sts_t sts;

  // sequencer
  sdtlb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_kind   (in_ch.data.kind),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // lines, z walk, result register
  sdtlb_dp #(.MAX_WIDTH(MAX_WIDTH)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_item   (in_ch.data),
    .cmd       (cmd),
    .sts       (sts),
    .out_item  (out_ch.data)
  );

  // result register is never overwritten while a beat still waits
  `SDTLB_ASSERT_NOW(a_out_no_overwrite, cmd.out_load, (!out_ch.valid || out_ch.ready), "result overwritten")

  // a clear always drops the drawn flag
  `SDTLB_ASSERT_NEXT(a_clear_drops_flag, cmd.clear_start, !sts.drawn, "drawn flag not cleared")

  // no beat is taken during a clearing pass or span walk
  `SDTLB_ASSERT_NOW(a_busy_not_ready, (cmd.sweep || cmd.span_run), !in_ch.ready, "accept while busy")

endmodule
